// ===== rtl/core/tctw_pkg.sv =====
// Shared types and constants of the texture coordinate transform and wrap unit.
package tctw_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_SCALE_U  = 3'd0,
        CFG_SCALE_V  = 3'd1,
        CFG_ROT_COS  = 3'd2,
        CFG_ROT_SIN  = 3'd3,
        CFG_SHIFT_U  = 3'd4,
        CFG_SHIFT_V  = 3'd5,
        CFG_TILE_UV  = 3'd6,
        CFG_WRAP_SEL = 3'd7
    } cfg_idx_t;

    // Wrap modes; the unused code behaves as clamp
    typedef enum logic [1:0] {
        WRAP_REPEAT = 2'd0,
        WRAP_MIRROR = 2'd1,
        WRAP_CLAMP  = 2'd2
    } wrap_mode_t;

    localparam int CoordW  = 32;   // input coordinate, Q16.16
    localparam int OutW    = 17;   // wrapped coordinate, Q0.16 in [0,1]
    localparam int CfgW    = 32;   // widest register
    localparam int CentW   = 33;   // coordinate minus one half
    localparam int ScaledW = 49;   // centred times scale, Q.24
    localparam int WideW   = 64;   // rotated, moved and tiled values
    localparam int FracW   = 46;   // fraction bits of the Q.38*256 and Q.46 steps
    localparam int RedW    = FracW + 1;

    localparam logic signed [CentW-1:0] Q16_HALF = 33'sd32768;
    localparam logic signed [WideW-1:0] Q38_HALF = 64'sd137438953472;
    localparam logic [RedW-1:0]         Q46_ONE  = 47'h4000_0000_0000;
    localparam logic [RedW-1:0]         RND_HALF = 47'h0000_2000_0000;

    // Reset values
    localparam logic signed [15:0] SCALE_RST = 16'sd256;
    localparam logic signed [15:0] COS_RST   = 16'sd16384;
    localparam logic [31:0]        TILE_RST  = 32'h0100_0100;

    typedef logic signed [WideW-1:0] wide_t;
    typedef logic signed [RedW-1:0]  red_t;

endpackage

// ===== rtl/core/texture_coord_transform_wrap_unit.sv =====
// Top level of the texture coordinate transform and wrap unit.
//
// Usage
//   s_* : input stream, one (u,v) pair per item; s_tdata = {coord_v, coord_u},
//         each signed Q16.16.
//   m_* : output stream, one wrapped pair per item; m_tdata holds wrapped_u
//         in bits 16:0 and wrapped_v in bits 33:17, unsigned Q0.16, zero pad above.
//   cfg_* : write-only register port, one register per cycle with cfg_we high.
//         Write only while the pipeline is empty.
// Timing
//   Six register stages; an item accepted on s_* passes through all six in order and
//   is presented on m_* from the last. One item per cycle sustained while m_* is not stalled:
//   every stage holds one item, so the rate is set by the single shared stage
//   enable, which follows the output register's freedom.
// Reset
//   rst_n clears all valid bits and loads the register defaults (unit scale,
//   no rotation, no shift, unit tiling, repeat).
// Stall
//   While m_tvalid is high and m_tready low, the whole pipe freezes and
//   s_tready drops; no item is dropped or duplicated. Bubbles are kept.
module texture_coord_transform_wrap_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    // config port
    input  logic                          cfg_we,
    input  tctw_pkg::cfg_idx_t            cfg_addr,
    input  logic [tctw_pkg::CfgW-1:0]     cfg_wdata,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [63:0]                   s_tdata,   // coord_u[31:0], coord_v[63:32]
    // output stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [39:0]                   m_tdata    // wrapped_u[16:0], wrapped_v[33:17]
);
    import tctw_pkg::*;

    localparam int Lanes = 2;   // lane 0 is u, lane 1 is v

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [15:0] scale_u_reg, scale_v_reg, rot_cos_reg, rot_sin_reg;
    logic signed [31:0] shift_u_reg, shift_v_reg;
    logic [31:0]        tile_uv_reg;
    wrap_mode_t         wrap_sel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_u_reg  <= SCALE_RST;
            scale_v_reg  <= SCALE_RST;
            rot_cos_reg  <= COS_RST;
            rot_sin_reg  <= '0;
            shift_u_reg  <= '0;
            shift_v_reg  <= '0;
            tile_uv_reg  <= TILE_RST;
            wrap_sel_reg <= WRAP_REPEAT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_SCALE_U:  scale_u_reg  <= cfg_wdata[15:0];
                CFG_SCALE_V:  scale_v_reg  <= cfg_wdata[15:0];
                CFG_ROT_COS:  rot_cos_reg  <= cfg_wdata[15:0];
                CFG_ROT_SIN:  rot_sin_reg  <= cfg_wdata[15:0];
                CFG_SHIFT_U:  shift_u_reg  <= cfg_wdata;
                CFG_SHIFT_V:  shift_v_reg  <= cfg_wdata;
                CFG_TILE_UV:  tile_uv_reg  <= cfg_wdata;
                CFG_WRAP_SEL: wrap_sel_reg <= wrap_mode_t'(cfg_wdata[1:0]);
                default:      ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: one shared enable, valid bits travel with the data
    // ------------------------------------------------------------------
    logic [5:1] vld_reg;
    logic       out_vld_reg;
    logic       adv;

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;
    assign m_tvalid = out_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg     <= {vld_reg[4:1], s_tvalid};
            out_vld_reg <= vld_reg[5];
        end
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    logic signed [15:0] scale    [Lanes];
    logic signed [WideW-1:0] shift_q38 [Lanes];
    logic [15:0]        tile     [Lanes];

    assign scale[0]     = scale_u_reg;
    assign scale[1]     = scale_v_reg;
    assign shift_q38[0] = {{10{shift_u_reg[31]}}, shift_u_reg, 22'b0};
    assign shift_q38[1] = {{10{shift_v_reg[31]}}, shift_v_reg, 22'b0};
    assign tile[0]      = tile_uv_reg[15:0];
    assign tile[1]      = tile_uv_reg[31:16];

    // stage 1: centre and scale
    logic signed [ScaledW-1:0] p_next [Lanes], p_reg [Lanes];
    // stage 2: rotation products: own lane by cos, own lane by sin
    wide_t pc_next [Lanes], pc_reg [Lanes];
    wide_t ps_next [Lanes], ps_reg [Lanes];
    // stage 3: rotate, add one half and the shift
    wide_t m_next [Lanes], m_reg [Lanes];
    // stage 4: truncating remainder by 256.0
    red_t  red_next [Lanes], red_reg [Lanes];
    // stage 5: tiling product
    wide_t prod_next [Lanes], prod_reg [Lanes];
    // stage 6: fraction, wrap and rounding
    logic [OutW-1:0] out_next [Lanes], out_reg [Lanes];

    always_comb
    begin
        logic signed [CentW-1:0] cent;
        logic [FracW-1:0]        low;
        logic [RedW-1:0]         wrapped;
        logic [RedW-1:0]         rounded;
        for (int i = 0; i < Lanes; i++)
        begin
            cent      = $signed({s_tdata[CoordW*i+CoordW-1], s_tdata[CoordW*i +: CoordW]})
                        - Q16_HALF;
            p_next[i] = cent * scale[i];

            pc_next[i] = p_reg[i] * rot_cos_reg;
            ps_next[i] = p_reg[i] * rot_sin_reg;

            // low bits and sign give the truncating remainder directly
            low         = m_reg[i][FracW-1:0];
            red_next[i] = (m_reg[i][WideW-1] && (low != '0)) ? {1'b1, low} : {1'b0, low};

            prod_next[i] = red_reg[i] * $signed({1'b0, tile[i]});

            low = prod_reg[i][FracW-1:0];
            if (prod_reg[i][WideW-1] && (low != '0))
            begin
                // fraction is low minus one, negative
                case (wrap_sel_reg)
                    WRAP_REPEAT: wrapped = {1'b0, low};
                    WRAP_MIRROR: wrapped = Q46_ONE - {1'b0, low};
                    default:     wrapped = '0;
                endcase
            end
            else
            begin
                wrapped = {1'b0, low};
            end
            rounded     = wrapped + RND_HALF;
            out_next[i] = rounded[RedW-1 -: OutW];
        end
        // rotation: u = p*cos - q*sin, v = p*sin + q*cos
        m_next[0] = pc_reg[0] - ps_reg[1] + Q38_HALF + shift_q38[0];
        m_next[1] = ps_reg[0] + pc_reg[1] + Q38_HALF + shift_q38[1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < Lanes; i++)
            begin
                p_reg[i]    <= p_next[i];
                pc_reg[i]   <= pc_next[i];
                ps_reg[i]   <= ps_next[i];
                m_reg[i]    <= m_next[i];
                red_reg[i]  <= red_next[i];
                prod_reg[i] <= prod_next[i];
                out_reg[i]  <= out_next[i];
            end
        end
    end

    assign m_tdata = {6'b0, out_reg[1], out_reg[0]};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_reg[0] <= 17'd65536) && (out_reg[1] <= 17'd65536))
        else $error("wrapped coordinate above 1.0");

    a_zero_tile: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && $stable(tile_uv_reg) && (tile_uv_reg[15:0] == '0)
        && $past(tile_uv_reg[15:0] == '0)
        && $past(tile_uv_reg[15:0] == '0, 2) |-> (out_reg[0] == '0))
        else $error("zero u tiling must give zero");

    a_rose: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(vld_reg[5]))
        else $error("output valid without an item in the last stage");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> ($stable(vld_reg) && $stable(out_reg[0]) && m_tvalid))
        else $error("pipe moved during an output stall");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking stream testbench for the texture coordinate transform and wrap unit.
module tb_top;
    import tctw_pkg::*;

    // No-progress limit: well above the long output hold plus worst-case gaps
    localparam int IdleLimit    = 2000;
    localparam int HoldCycles   = 300;   // long output back-pressure stretch
    localparam int DrainCycles  = 10;    // pipe depth plus margin
    localparam int RandPhases   = 12;
    localparam int PhaseItems   = 44;
    // Spare wrap code, not in the package enum; the unit treats it as clamp
    localparam logic [1:0] WRAP_SPARE = 2'd3;
    localparam longint Q46One   = longint'(1) <<< 46;   // 1.0 in Q.46, also 256.0 in Q.38
    localparam longint RoundQ16 = longint'(1) <<< 29;   // half an output LSB in Q.46

    typedef struct {
        logic [OutW-1:0] u;
        logic [OutW-1:0] v;
    } wrapped_pair_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    cfg_idx_t             cfg_addr  = CFG_SCALE_U;
    logic [CfgW-1:0]      cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [63:0]          s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [39:0]          m_tdata;

    // Local copy of the register file, kept in step with every write
    logic signed [15:0]   mdl_scale_u = SCALE_RST;
    logic signed [15:0]   mdl_scale_v = SCALE_RST;
    logic signed [15:0]   mdl_cos     = COS_RST;
    logic signed [15:0]   mdl_sin     = '0;
    logic signed [31:0]   mdl_shift_u = '0;
    logic signed [31:0]   mdl_shift_v = '0;
    logic [31:0]          mdl_tile    = TILE_RST;
    logic [1:0]           mdl_wrap    = WRAP_REPEAT;

    logic [63:0]          coord_pend_q[$];     // pairs waiting for the driver
    wrapped_pair_t        wrapped_due_q[$];    // predicted pairs, oldest first

    logic                 in_taken    = 1'b0;  // handshake seen at the last rising edge
    logic                 out_taken   = 1'b0;
    logic                 src_idle_on = 1'b0;  // random gaps on the sender side
    logic                 rx_idle_on  = 1'b0;  // random stalls on the receiver side
    int                   queued_cnt  = 0;
    int                   taken_cnt   = 0;
    int                   checked_cnt = 0;
    int                   fault_cnt   = 0;
    int                   setup_cnt   = 0;
    int                   idle_cycles = 0;
    int                   hold_ticket = 0;
    int                   hold_served = 0;
    int                   hold_left   = 0;
    int                   tx_wait     = 0;
    int                   rx_wait     = 0;
    logic [3:0]           wrap_seen   = '0;

    texture_coord_transform_wrap_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // coord_u[31:0], coord_v[63:32]
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)     // wrapped_u[16:0], wrapped_v[33:17], zero pad above
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Tile, drop the integer part (sign kept), wrap, round to Q0.16.
    // moved is Q.38; it is first cut modulo 256.0, which leaves the fraction alone.
    function automatic logic [OutW-1:0] fold_axis(input longint moved, input longint tile);
        longint red;
        longint frac;
        red  = moved % Q46One;
        frac = (red * tile) % Q46One;
        if (frac < 0)
        begin
            if (mdl_wrap == WRAP_REPEAT)
                frac = frac + Q46One;
            else if (mdl_wrap == WRAP_MIRROR)
                frac = -frac;          // 2 - (f + 2) folds back to -f
            else
                frac = 0;              // clamp, and the spare code
        end
        // a fraction just under 1.0 may round up to 65536
        return OutW'((frac + RoundQ16) >>> 30);
    endfunction

    function automatic wrapped_pair_t predict_wrapped(input logic [63:0] pair);
        longint cu;
        longint cv;
        longint pu;
        longint pv;
        longint mu;
        longint mv;
        wrapped_pair_t res;
        cu = longint'($signed(pair[31:0]));
        cv = longint'($signed(pair[63:32]));
        // centre on 0.5 and scale: Q16.16 * Q8.8 -> Q.24
        pu = (cu - longint'(Q16_HALF)) * longint'(mdl_scale_u);
        pv = (cv - longint'(Q16_HALF)) * longint'(mdl_scale_v);
        // rotate (Q.38), then move back by 0.5 plus the shift
        mu = pu * longint'(mdl_cos) - pv * longint'(mdl_sin) + longint'(Q38_HALF)
             + longint'(mdl_shift_u) * (longint'(1) <<< 22);
        mv = pu * longint'(mdl_sin) + pv * longint'(mdl_cos) + longint'(Q38_HALF)
             + longint'(mdl_shift_v) * (longint'(1) <<< 22);
        res.u = fold_axis(mu, longint'(mdl_tile[15:0]));
        res.v = fold_axis(mv, longint'(mdl_tile[31:16]));
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Sender: one item from the pending queue at a time, gap drawn per item
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || in_taken)
            begin
                if (tx_wait > 0)
                begin
                    s_tvalid <= 1'b0;
                    tx_wait = tx_wait - 1;
                end
                else if (coord_pend_q.size() != 0)
                begin
                    s_tdata  <= coord_pend_q.pop_front();
                    s_tvalid <= 1'b1;
                    tx_wait = src_idle_on ? $urandom_range(0, 14) : 0;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Long output hold, timed here; the stimulus only asks for it
    always @(negedge clk)
    begin
        if (hold_ticket != hold_served)
        begin
            hold_served <= hold_ticket;
            hold_left   <= HoldCycles;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // Receiver: stall drawn after every accepted item, plus the long hold
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_taken)
                rx_wait = rx_idle_on ? $urandom_range(0, 14) : 0;
            if (rx_wait > 0)
            begin
                m_tready <= 1'b0;
                rx_wait = rx_wait - 1;
            end
            else
                m_tready <= (hold_left == 0);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on input acceptance, check on output acceptance
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        wrapped_pair_t got;
        wrapped_pair_t want;
        if (rst_n)
        begin
            in_taken  <= s_tvalid && s_tready;
            out_taken <= m_tvalid && m_tready;
            if (s_tvalid && s_tready)
            begin
                wrapped_due_q.push_back(predict_wrapped(s_tdata));
                wrap_seen[mdl_wrap] <= 1'b1;
                taken_cnt <= taken_cnt + 1;
            end
            if (m_tvalid && m_tready)
            begin
                got.u = m_tdata[OutW-1:0];
                got.v = m_tdata[2*OutW-1:OutW];
                if (wrapped_due_q.size() == 0)
                begin
                    fault_cnt <= fault_cnt + 1;
                    if (fault_cnt < 10)
                        $display("unexpected item: wrapped_u %0d wrapped_v %0d", got.u, got.v);
                end
                else
                begin
                    want = wrapped_due_q.pop_front();
                    if (got.u !== want.u || got.v !== want.v)
                    begin
                        fault_cnt <= fault_cnt + 1;
                        if (fault_cnt < 10)
                            $display("item %0d: wrapped_u exp %0d got %0d, wrapped_v exp %0d got %0d",
                                     checked_cnt, want.u, got.u, want.v, got.v);
                    end
                    checked_cnt <= checked_cnt + 1;
                end
            end
        end
    end

    // Watchdog: cycles without any handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else if (idle_cycles >= IdleLimit)
            begin
                $display("watchdog: no item moved for %0d cycles", IdleLimit);
                $display("CHECKS FAILED");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic write_reg(input cfg_idx_t idx, input logic [CfgW-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_SCALE_U:  mdl_scale_u = val[15:0];
            CFG_SCALE_V:  mdl_scale_v = val[15:0];
            CFG_ROT_COS:  mdl_cos     = val[15:0];
            CFG_ROT_SIN:  mdl_sin     = val[15:0];
            CFG_SHIFT_U:  mdl_shift_u = val;
            CFG_SHIFT_V:  mdl_shift_v = val;
            CFG_TILE_UV:  mdl_tile    = val;
            CFG_WRAP_SEL: mdl_wrap    = val[1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_setup(input logic [15:0] su, input logic [15:0] sv,
                              input logic [15:0] rc, input logic [15:0] rs,
                              input logic [31:0] hu, input logic [31:0] hv,
                              input logic [31:0] tile, input logic [1:0] wrap);
        write_reg(CFG_SCALE_U, {{16{su[15]}}, su});
        write_reg(CFG_SCALE_V, {{16{sv[15]}}, sv});
        write_reg(CFG_ROT_COS, {{16{rc[15]}}, rc});
        write_reg(CFG_ROT_SIN, {{16{rs[15]}}, rs});
        write_reg(CFG_SHIFT_U, hu);
        write_reg(CFG_SHIFT_V, hv);
        write_reg(CFG_TILE_UV, tile);
        write_reg(CFG_WRAP_SEL, {30'd0, wrap});
        setup_cnt++;
    endtask

    task automatic send_pair(input logic [31:0] u, input logic [31:0] v);
        coord_pend_q.push_back({v, u});
        queued_cnt++;
    endtask

    // Everything sent has been accepted and answered, then a few spare cycles
    task automatic wait_drained;
        do
            @(negedge clk);
        while (taken_cnt != queued_cnt || wrapped_due_q.size() != 0);
        repeat (DrainCycles) @(negedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        logic [15:0] fr;
        case ($urandom_range(0, 3))
            0, 1:    return 32'($urandom_range(0, 1048576)) - 32'd524288;   // within +-8.0
            2:       return $urandom;
            default:
            begin
                // integer part at random, fraction at an edge
                case ($urandom_range(0, 3))
                    0:       fr = 16'h0000;
                    1:       fr = 16'hFFFF;
                    2:       fr = 16'h8000;
                    default: fr = 16'h7FFF;
                endcase
                return {16'($urandom), fr};
            end
        endcase
    endfunction

    function automatic logic [15:0] rand_scale();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return SCALE_RST;
            3:       return 16'($urandom);
            default: return 16'($urandom_range(0, 1023)) - 16'd512;   // within +-2.0
        endcase
    endfunction

    function automatic logic [15:0] rand_trig();
        case ($urandom_range(0, 4))
            0:       return 16'hC000;    // -1.0
            1:       return 16'h4000;    // +1.0
            default: return 16'($urandom_range(0, 32768)) - 16'd16384;
        endcase
    endfunction

    function automatic logic [31:0] rand_shift();
        case ($urandom_range(0, 4))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return $urandom;
            default: return 32'($urandom_range(0, 524288)) - 32'd262144;   // within +-4.0
        endcase
    endfunction

    function automatic logic [15:0] rand_tile();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h0100;
            3:       return 16'($urandom);
            default: return 16'($urandom_range(0, 2047));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        int ph;
        int n;
        int total_faults;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset values: unit scale, no rotation, unit tiling, repeat
        send_pair(32'h0000_0000, 32'h0000_0000);
        send_pair(32'h0000_8000, 32'h0000_8000);
        send_pair(32'h7FFF_FFFF, 32'h8000_0000);
        send_pair(32'h8000_0000, 32'h7FFF_FFFF);
        send_pair(32'h0001_0000, 32'hFFFF_8000);
        send_pair(32'hFFFF_FFFF, 32'h0000_0001);
        send_pair(32'hFFFF_0000, 32'h0001_8000);
        wait_drained();

        // Register extremes, full tiling on both axes, mirror
        load_setup(16'h8000, 16'h7FFF, 16'hC000, 16'h4000,
                   32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, WRAP_MIRROR);
        send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_pair(32'h8000_0000, 32'h8000_0000);
        send_pair(32'h1234_5678, 32'hFEDC_BA98);
        send_pair(32'h0000_0000, 32'hFFFF_FFFF);
        wait_drained();

        // Clamp, v tiling zero; u lands just under 1.0 and rounds up
        load_setup(16'h0001, SCALE_RST, COS_RST, 16'h0000,
                   32'h0, 32'h0, 32'h0000_0100, WRAP_CLAMP);
        send_pair(32'hFFFF_0000, 32'h0000_4000);
        send_pair(32'h0000_4000, 32'hFFFF_0000);
        send_pair(32'h0080_7FFF, 32'h0001_2345);
        wait_drained();

        // Spare wrap code with tiny scale; then the same pairs in mirror and repeat
        load_setup(16'h0001, 16'h0001, COS_RST, 16'h0000,
                   32'h0, 32'h0, TILE_RST, WRAP_SPARE);
        send_pair(32'h0080_7FFF, 32'hFF80_7FFF);
        send_pair(32'hFFFF_0000, 32'hFFFF_7000);
        wait_drained();
        write_reg(CFG_WRAP_SEL, {30'd0, WRAP_MIRROR});
        send_pair(32'h0080_7FFF, 32'hFF80_7FFF);
        send_pair(32'hFFFF_0000, 32'hFFFF_7000);
        wait_drained();
        write_reg(CFG_WRAP_SEL, {30'd0, WRAP_REPEAT});
        send_pair(32'h0080_7FFF, 32'hFF80_7FFF);
        send_pair(32'hFFFF_0000, 32'hFFFF_7000);
        wait_drained();

        // Random settings and random pairs, one setting per phase
        for (ph = 0; ph < RandPhases; ph++)
        begin
            load_setup(rand_scale(), rand_scale(), rand_trig(), rand_trig(),
                       rand_shift(), rand_shift(), {rand_tile(), rand_tile()},
                       2'($urandom_range(0, 3)));
            // first phase streams flat out; others mix idling at random
            src_idle_on = (ph != 0) && ($urandom_range(0, 2) != 0);
            rx_idle_on  = (ph != 0) && ($urandom_range(0, 2) != 0);
            if (ph == 4)
            begin
                // receiver holds off while the sender keeps offering: pipe fills
                src_idle_on = 1'b0;
                hold_ticket = hold_ticket + 1;
            end
            if (ph == 7)
            begin
                // sender stops half way until every answer is back
                for (n = 0; n < PhaseItems / 2; n++)
                    send_pair(rand_coord(), rand_coord());
                wait_drained();
                for (n = PhaseItems / 2; n < PhaseItems; n++)
                    send_pair(rand_coord(), rand_coord());
            end
            else
            begin
                for (n = 0; n < PhaseItems; n++)
                    send_pair(rand_coord(), rand_coord());
            end
            wait_drained();
        end

        total_faults = fault_cnt + wrapped_due_q.size();
        if (wrapped_due_q.size() != 0)
            $display("%0d predicted items never came out", wrapped_due_q.size());
        $display("run: %0d coordinate pairs in, %0d results compared, %0d register setups",
                 taken_cnt, checked_cnt, setup_cnt);
        $display("wrap codes exercised (bit per code): %b, with long output hold and sender drain",
                 wrap_seen);
        if (total_faults == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
